[hw/rtl/gusc_pkg.sv]
package gusc_pkg;

    localparam logic [7:0] UTF_LEAD_MIN  = 8'h80;
    localparam logic [7:0] UTF_LEAD6_LO  = 8'hFC;
    localparam logic [7:0] UTF_LEAD6_HI  = 8'hFD;
    localparam logic [7:0] UTF_LEAD5_MIN = 8'hF8;
    localparam logic [7:0] UTF_LEAD4_MIN = 8'hF0;
    localparam logic [7:0] UTF_LEAD3_MIN = 8'hE0;
    localparam logic [7:0] UTF_LEAD2_MIN = 8'hC0;
    localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
    localparam logic [7:0] UTF_CONT_TAG  = 8'h80;
    localparam logic [7:0] GBK_LEAD_MIN  = 8'h81;
    localparam logic [7:0] GBK_BAD_BYTE  = 8'hFF;
    localparam logic [7:0] GBK_TRAIL_MIN = 8'h40;
    localparam logic [7:0] GBK_TRAIL_GAP = 8'h7F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } gusc_beat_t;

    typedef struct packed {
        logic is_gbk;
        logic utf8_valid;
        logic gbk_valid;
    } gusc_verdict_t;

    typedef struct packed {
        logic [2:0] utf_bytes_pending;
        logic       utf_failed;
        logic       all_ascii_so_far;
        logic       gbk_expect_trail;
        logic       gbk_failed;
        logic       gbk_pair_seen;
    } gusc_state_t;

    localparam gusc_state_t GUSC_STATE_RESET = '{
        utf_bytes_pending: 3'd0,
        utf_failed:        1'b0,
        all_ascii_so_far:  1'b1,
        gbk_expect_trail:  1'b0,
        gbk_failed:        1'b0,
        gbk_pair_seen:     1'b0
    };

endpackage

[hw/rtl/gusc_byte_if.sv]
interface gusc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/gusc_verdict_if.sv]
interface gusc_verdict_if;
    logic valid;
    logic ready;
    logic is_gbk;
    logic utf8_valid;
    logic gbk_valid;

    modport source (output valid, output is_gbk, output utf8_valid, output gbk_valid,
                    input ready);
    modport sink   (input valid, input is_gbk, input utf8_valid, input gbk_valid,
                    output ready);
endinterface

[hw/rtl/gbk_vs_utf8_ssid_classifier.sv]
// channel   | dir | payload                          | beat rule
// ssid_in   | in  | data_byte[7:0], last_byte        | valid & ready
// result    | out | is_gbk, utf8_valid, gbk_valid    | valid & ready, one per SSID
//
// One byte per cycle sustained while no last byte waits on the result side.
// A byte sits in the input register, then one pass updates the check flags.
// The result register parts the two sides; ready drops only while a last byte
// waits behind an untaken result. Reset restores the start check flags and clears the valids.
module gbk_vs_utf8_ssid_classifier
    import gusc_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    gusc_byte_if.sink     ssid_in,
    gusc_verdict_if.source result
);

    logic          s1_valid_reg;
    logic          s1_valid_next;
    gusc_beat_t    s1_beat_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    gusc_verdict_t out_verdict_reg;
    gusc_verdict_t verdict;
    logic          out_free;
    logic          s1_adv;
    logic          in_fire;

    assign out_free = !out_valid_reg || result.ready;
    assign s1_adv   = s1_valid_reg && (!s1_beat_reg.last_byte || out_free);
    assign ssid_in.ready = !s1_valid_reg || s1_adv;
    assign in_fire  = ssid_in.valid && ssid_in.ready;

    gusc_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .beat    (s1_beat_reg),
        .verdict (verdict)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_beat_reg.last_byte)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload unless a new beat lands
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_beat_reg.data_byte <= ssid_in.data_byte;
            s1_beat_reg.last_byte <= ssid_in.last_byte;
        end
        if (s1_adv && s1_beat_reg.last_byte)
            out_verdict_reg <= verdict;
    end

    assign result.valid      = out_valid_reg;
    assign result.is_gbk     = out_verdict_reg.is_gbk;
    assign result.utf8_valid = out_verdict_reg.utf8_valid;
    assign result.gbk_valid  = out_verdict_reg.gbk_valid;

endmodule

[hw/rtl/gusc_engine.sv]
module gusc_engine
    import gusc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  gusc_beat_t    beat,
    output gusc_verdict_t verdict
);

    gusc_state_t st_reg;
    gusc_state_t upd;
    gusc_state_t st_next;
    logic [7:0]  b;
    logic        utf_ok;
    logic        gbk_ok;

    assign b = beat.data_byte;

    always_comb
    begin
        upd = st_reg;
        upd.all_ascii_so_far = st_reg.all_ascii_so_far & ~b[7];

        if (!st_reg.utf_failed)
        begin
            if (st_reg.utf_bytes_pending == 3'd0)
            begin
                priority if (b < UTF_LEAD_MIN)
                    upd.utf_bytes_pending = 3'd0;
                else if (b >= UTF_LEAD6_LO && b <= UTF_LEAD6_HI)
                    upd.utf_bytes_pending = 3'd5;
                else if (b >= UTF_LEAD5_MIN)
                    upd.utf_bytes_pending = 3'd4;
                else if (b >= UTF_LEAD4_MIN)
                    upd.utf_bytes_pending = 3'd3;
                else if (b >= UTF_LEAD3_MIN)
                    upd.utf_bytes_pending = 3'd2;
                else if (b >= UTF_LEAD2_MIN)
                    upd.utf_bytes_pending = 3'd1;
                else
                    upd.utf_failed = 1'b1;
            end
            else if ((b & UTF_CONT_MASK) != UTF_CONT_TAG)
            begin
                upd.utf_failed = 1'b1;
            end
            else
            begin
                upd.utf_bytes_pending = st_reg.utf_bytes_pending - 3'd1;
            end
        end

        if (!st_reg.gbk_failed)
        begin
            priority if (st_reg.gbk_expect_trail)
            begin
                upd.gbk_expect_trail = 1'b0;
                if (b >= GBK_TRAIL_MIN && b != GBK_BAD_BYTE && b != GBK_TRAIL_GAP)
                    upd.gbk_pair_seen = 1'b1;
                else
                    upd.gbk_failed = 1'b1;
            end
            else if (b >= GBK_LEAD_MIN && b != GBK_BAD_BYTE && !beat.last_byte)
                upd.gbk_expect_trail = 1'b1;
            else if (b >= UTF_LEAD_MIN)
                upd.gbk_failed = 1'b1;
            else
                upd.gbk_expect_trail = 1'b0;
        end
    end

    assign utf_ok = !upd.utf_failed && (upd.utf_bytes_pending == 3'd0)
                    && !upd.all_ascii_so_far;
    assign gbk_ok = !upd.gbk_failed && !upd.gbk_expect_trail && upd.gbk_pair_seen;

    assign verdict.is_gbk     = gbk_ok & ~utf_ok;
    assign verdict.utf8_valid = utf_ok;
    assign verdict.gbk_valid  = gbk_ok;

    always_comb
    begin
        st_next = st_reg;
        if (advance)
            st_next = beat.last_byte ? GUSC_STATE_RESET : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= GUSC_STATE_RESET;
        else
            st_reg <= st_next;
    end

endmodule

[hw/rtl/gusc_props.sv]
module gusc_props
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic is_gbk,
    input logic utf8_valid,
    input logic gbk_valid
);

    a_gbk_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_gbk == (gbk_valid && !utf8_valid)))
        else $error("is_gbk disagrees with gbk_valid and utf8_valid");

    a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while result side is free");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(is_gbk) && $stable(utf8_valid) && $stable(gbk_valid)))
        else $error("stalled result beat changed");

endmodule

bind gbk_vs_utf8_ssid_classifier gusc_props u_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (ssid_in.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .is_gbk     (result.is_gbk),
    .utf8_valid (result.utf8_valid),
    .gbk_valid  (result.gbk_valid)
);

[bench/tb_gbk_vs_utf8_ssid_classifier.sv]
`timescale 1ns / 100ps

module tb_gbk_vs_utf8_ssid_classifier;
    import gusc_pkg::*;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    typedef enum logic [2:0] {
        SSID_ASCII,
        SSID_UTF8,
        SSID_UTF8_BROKEN,
        SSID_GBK,
        SSID_GBK_BROKEN,
        SSID_NOISE
    } ssid_kind_t;

    localparam int RANDOM_BYTES = 1650;
    localparam int MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    gusc_byte_if    ssid_in_if ();
    gusc_verdict_if result_if ();

    gbk_vs_utf8_ssid_classifier u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .ssid_in(ssid_in_if),
        .result (result_if)
    );

    gusc_beat_t    pending_beats[$];
    gusc_verdict_t verdicts_due[$];
    logic [7:0]    ssid_buf[$];

    gusc_state_t   ssid_state;
    gusc_verdict_t got_verdict;
    gusc_verdict_t want_verdict;
    logic          byte_taken;
    int            error_count;

    int            burst_left;
    int            gap_left;
    rx_mode_t      rx_mode;
    int            rx_phase_left;
    logic [1:0]    rx_tick;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic gusc_state_t advance_ssid_checks(gusc_state_t s, logic [7:0] b,
                                                        logic last);
        gusc_state_t n;
        n = s;
        if (b[7])
            n.all_ascii_so_far = 1'b0;
        if (!s.utf_failed)
        begin
            if (s.utf_bytes_pending == 3'd0)
            begin
                if (b >= UTF_LEAD_MIN)
                begin
                    if (b >= UTF_LEAD6_LO && b <= UTF_LEAD6_HI)
                        n.utf_bytes_pending = 3'd5;
                    else if (b >= UTF_LEAD5_MIN)
                        n.utf_bytes_pending = 3'd4;
                    else if (b >= UTF_LEAD4_MIN)
                        n.utf_bytes_pending = 3'd3;
                    else if (b >= UTF_LEAD3_MIN)
                        n.utf_bytes_pending = 3'd2;
                    else if (b >= UTF_LEAD2_MIN)
                        n.utf_bytes_pending = 3'd1;
                    else
                        n.utf_failed = 1'b1;
                end
            end
            else if ((b & UTF_CONT_MASK) != UTF_CONT_TAG)
                n.utf_failed = 1'b1;
            else
                n.utf_bytes_pending = s.utf_bytes_pending - 3'd1;
        end
        if (!s.gbk_failed)
        begin
            if (s.gbk_expect_trail)
            begin
                n.gbk_expect_trail = 1'b0;
                if (b >= GBK_TRAIL_MIN && b != GBK_BAD_BYTE && b != GBK_TRAIL_GAP)
                    n.gbk_pair_seen = 1'b1;
                else
                    n.gbk_failed = 1'b1;
            end
            else if (b >= GBK_LEAD_MIN && b != GBK_BAD_BYTE && !last)
                n.gbk_expect_trail = 1'b1;
            else if (b[7])
                n.gbk_failed = 1'b1;
        end
        return n;
    endfunction

    function automatic gusc_verdict_t ssid_verdict(gusc_state_t s);
        gusc_verdict_t v;
        v.utf8_valid = !s.utf_failed && s.utf_bytes_pending == 3'd0 && !s.all_ascii_so_far;
        v.gbk_valid  = !s.gbk_failed && !s.gbk_expect_trail && s.gbk_pair_seen;
        v.is_gbk     = v.gbk_valid && !v.utf8_valid;
        return v;
    endfunction

    // sample both channels and predict
    always @(posedge clk)
    begin
        byte_taken = 1'b0;
        if (rst_n)
        begin
            if (ssid_in_if.valid && ssid_in_if.ready)
            begin
                byte_taken = 1'b1;
                ssid_state = advance_ssid_checks(ssid_state, ssid_in_if.data_byte,
                                                 ssid_in_if.last_byte);
                if (ssid_in_if.last_byte)
                begin
                    verdicts_due.push_back(ssid_verdict(ssid_state));
                    ssid_state = GUSC_STATE_RESET;
                end
            end
            if (result_if.valid && result_if.ready)
            begin
                got_verdict = '{is_gbk:     result_if.is_gbk,
                                utf8_valid: result_if.utf8_valid,
                                gbk_valid:  result_if.gbk_valid};
                if (verdicts_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: verdict with none due: is_gbk=%b utf8=%b gbk=%b",
                                 $realtime, got_verdict.is_gbk, got_verdict.utf8_valid,
                                 got_verdict.gbk_valid);
                end
                else
                begin
                    want_verdict = verdicts_due.pop_front();
                    if (got_verdict.is_gbk !== want_verdict.is_gbk ||
                        got_verdict.utf8_valid !== want_verdict.utf8_valid ||
                        got_verdict.gbk_valid !== want_verdict.gbk_valid)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"%0t: verdict mismatch: ",
                                      "expected is_gbk=%b utf8=%b gbk=%b, ",
                                      "got is_gbk=%b utf8=%b gbk=%b"},
                                     $realtime, want_verdict.is_gbk,
                                     want_verdict.utf8_valid, want_verdict.gbk_valid,
                                     got_verdict.is_gbk, got_verdict.utf8_valid,
                                     got_verdict.gbk_valid);
                    end
                end
            end
        end
    end

    // drive bytes in bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            ssid_in_if.valid <= 1'b0;
            burst_left       <= 0;
            gap_left         <= 0;
        end
        else if (!ssid_in_if.valid || byte_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left         <= gap_left - 1;
                ssid_in_if.valid <= 1'b0;
            end
            else if (pending_beats.size() == 0)
                ssid_in_if.valid <= 1'b0;
            else
            begin
                ssid_in_if.valid     <= 1'b1;
                ssid_in_if.data_byte <= pending_beats[0].data_byte;
                ssid_in_if.last_byte <= pending_beats[0].last_byte;
                void'(pending_beats.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // stall the result side
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            rx_mode         <= RX_ALWAYS;
            rx_phase_left   <= 0;
            rx_tick         <= 2'd0;
        end
        else
        begin
            if (rx_phase_left == 0)
            begin
                rx_mode       <= rx_mode_t'($urandom_range(0, 3));
                rx_phase_left <= $urandom_range(20, 200);
            end
            else
                rx_phase_left <= rx_phase_left - 1;
            rx_tick <= rx_tick + 2'd1;
            case (rx_mode)
                RX_ALWAYS:   result_if.ready <= 1'b1;
                RX_COIN:     result_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   result_if.ready <= ($urandom_range(0, 4) == 0);
                default:     result_if.ready <= (rx_tick != 2'b11);
            endcase
        end
    end

    task automatic queue_ssid();
        gusc_beat_t beat;
        for (int i = 0; i < ssid_buf.size(); i++)
        begin
            beat.data_byte = ssid_buf[i];
            beat.last_byte = (i == ssid_buf.size() - 1);
            pending_beats.push_back(beat);
        end
        ssid_buf.delete();
    endtask

    task automatic queue_packed(input logic [47:0] seq, input int n);
        for (int i = n - 1; i >= 0; i--)
            ssid_buf.push_back(seq[i*8 +: 8]);
        queue_ssid();
    endtask

    task automatic push_utf8_char();
        int n;
        n = $urandom_range(2, 6);
        case (n)
            2: ssid_buf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            3: ssid_buf.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            4: ssid_buf.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            5: ssid_buf.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'hF8, 8'hFB)
                                                          : $urandom_range(8'hFE, 8'hFF)));
            default: ssid_buf.push_back(8'($urandom_range(8'hFC, 8'hFD)));
        endcase
        for (int i = 1; i < n; i++)
            ssid_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    task automatic push_gbk_pair();
        logic [7:0] t;
        ssid_buf.push_back(8'($urandom_range(8'h81, 8'hFE)));
        do
            t = 8'($urandom_range(8'h40, 8'hFE));
        while (t == GBK_TRAIL_GAP);
        ssid_buf.push_back(t);
    endtask

    task automatic build_random_ssid();
        ssid_kind_t kind;
        int         len_goal;
        int         idx;
        kind     = ssid_kind_t'($urandom_range(0, 5));
        len_goal = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 16);
        while (ssid_buf.size() < len_goal)
        begin
            case (kind)
                SSID_ASCII:
                    ssid_buf.push_back(8'($urandom_range(0, 8'h7F)));
                SSID_UTF8, SSID_UTF8_BROKEN:
                    if ($urandom_range(0, 2) == 0)
                        ssid_buf.push_back(8'($urandom_range(0, 8'h7F)));
                    else
                        push_utf8_char();
                SSID_GBK, SSID_GBK_BROKEN:
                    if ($urandom_range(0, 2) == 0)
                        ssid_buf.push_back(8'($urandom_range(0, 8'h7F)));
                    else
                        push_gbk_pair();
                default:
                    ssid_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if ((kind == SSID_UTF8_BROKEN || kind == SSID_GBK_BROKEN) && ssid_buf.size() > 1)
        begin
            if ($urandom_range(0, 1) == 0)
                void'(ssid_buf.pop_back());
            else
            begin
                idx = $urandom_range(0, ssid_buf.size() - 1);
                ssid_buf[idx] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_beats.size() != 0 || ssid_in_if.valid || verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int random_bytes;
        int ssid_count;
        rst_n                = 1'b0;
        ssid_in_if.valid     = 1'b0;
        ssid_in_if.data_byte = 8'h00;
        ssid_in_if.last_byte = 1'b0;
        result_if.ready      = 1'b0;
        ssid_state           = GUSC_STATE_RESET;
        byte_taken           = 1'b0;
        error_count          = 0;
        random_bytes         = 0;
        ssid_count           = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_packed(48'h00, 1);
        queue_packed(48'hFF, 1);
        queue_packed(48'h81, 1);
        queue_packed(48'hC3A9, 2);
        queue_packed(48'hFC8080808080, 6);
        queue_packed(48'hD6D0, 2);
        queue_packed(48'h807F, 2);
        queue_packed(48'h817F, 2);
        queue_packed(48'hFE40, 2);
        queue_packed(48'hE4B8, 2);

        // hold the sender until every verdict is back
        wait_for_drain();

        while (random_bytes < RANDOM_BYTES)
        begin
            @(posedge clk);
            build_random_ssid();
            random_bytes += ssid_buf.size();
            queue_ssid();
            ssid_count++;
            if (ssid_count % 40 == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hw/rtl/gusc_pkg.sv
hw/rtl/gusc_byte_if.sv
hw/rtl/gusc_verdict_if.sv
hw/rtl/gusc_engine.sv
hw/rtl/gbk_vs_utf8_ssid_classifier.sv
hw/rtl/gusc_props.sv
bench/tb_gbk_vs_utf8_ssid_classifier.sv
